@@ rtl/lddsc_pkg.sv @@
// Shared types and constants for the LED driver serial command sender.
// Used by the bit shifter, the core and the port checker; depends on nothing.
package lddsc_pkg;

    localparam int CMD_BITS = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATA_CMD_FIXED     = 3'd0,
        CFG_DATA_CMD_INCREMENT = 3'd1,
        CFG_ADDRESS_CMD_BASE   = 3'd2,
        CFG_DISPLAY_CTRL_CMD   = 3'd3,
        CFG_DISPLAY_MODE_CMD   = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_MODE_SET = 2'd0,
        KIND_FIXED    = 2'd1,
        KIND_BURST    = 2'd2,
        KIND_UNUSED   = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CMD  = 5'b00010,
        ST_ADDR = 5'b00100,
        ST_WORD = 5'b01000,
        ST_CTRL = 5'b10000
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } sh_ctrl_t;

    localparam logic [CFG_DATA_W-1:0] RST_DATA_CMD_FIXED     = 8'h44;
    localparam logic [CFG_DATA_W-1:0] RST_DATA_CMD_INCREMENT = 8'h40;
    localparam logic [CFG_DATA_W-1:0] RST_ADDRESS_CMD_BASE   = 8'hC0;
    localparam logic [CFG_DATA_W-1:0] RST_DISPLAY_CTRL_CMD   = 8'h8F;
    localparam logic [CFG_DATA_W-1:0] RST_DISPLAY_MODE_CMD   = 8'h03;

endpackage

@@ rtl/lddsc_shifter.sv @@
// One-bit-per-cycle shift register, while ctrl.shift is set, with a remaining-bit counter.
// Depends on lddsc_pkg for the control struct.
module lddsc_shifter
    import lddsc_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sh_ctrl_t                     ctrl,
    input  logic [WIDTH-1:0]             load_data,
    input  logic [$clog2(WIDTH)-1:0]     load_count,
    output logic                         bit_out,
    output logic                         seg_done
);

    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH-1:0] shift_reg;
    logic [WIDTH-1:0] shift_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        if (ctrl.load)
        begin
            shift_next = load_data;
            cnt_next   = load_count;
        end
        else if (ctrl.shift)
        begin
            shift_next = shift_reg >> 1;
            cnt_next   = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign bit_out  = shift_reg[0];
    assign seg_done = (cnt_reg == '0);

endmodule

@@ rtl/led_driver_serial_command_sender_core.sv @@
// Top level of the LED driver serial command sender: configuration registers,
// request sequencer and output handshake. Depends on lddsc_pkg and lddsc_shifter.
//
// Each accepted request is sent as a sequence of single serial bits, LSB first,
// one bit per cycle while the output is not stalled: 8 bits for a mode-set,
// 8 + 8 + DATA_BITS + 8 bits for a fixed-address write (40 at DATA_BITS = 16),
// and DATA_BITS, DATA_BITS + 8, DATA_BITS + 16 or DATA_BITS + 24 bits for a burst
// word, depending on whether it opens the burst and whether it is the last word.
// An unused kind is accepted and produces nothing. Every command, address and data
// field goes through the single one-bit shifter, and in_stall stays high until the
// final bit of the current request is taken.
module led_driver_serial_command_sender_core
    import lddsc_pkg::*;
#(
    parameter int DATA_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            kind,
    input  logic [3:0]            display_address,
    input  logic [15:0]           word_data,
    input  logic                  last_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  serial_bit,
    output logic                  strobe_release,
    output logic                  last
);

    localparam int CNT_W = $clog2(DATA_BITS);
    localparam logic [CNT_W-1:0] CMD_COUNT  = CNT_W'(CMD_BITS - 1);
    localparam logic [CNT_W-1:0] WORD_COUNT = CNT_W'(DATA_BITS - 1);

    logic [CFG_DATA_W-1:0] data_cmd_fixed_reg;
    logic [CFG_DATA_W-1:0] data_cmd_increment_reg;
    logic [CFG_DATA_W-1:0] address_cmd_base_reg;
    logic [CFG_DATA_W-1:0] display_ctrl_cmd_reg;
    logic [CFG_DATA_W-1:0] display_mode_cmd_reg;

    state_t state_reg;
    state_t state_next;
    logic   burst_open_reg;
    logic   burst_open_next;
    logic   mode_set_reg;
    logic   mode_set_next;
    logic   word_release_reg;
    logic   word_release_next;
    logic   ctrl_pending_reg;
    logic   ctrl_pending_next;

    logic [3:0]           addr_reg;
    logic [DATA_BITS-1:0] word_reg;

    sh_ctrl_t             sh_ctrl;
    logic [DATA_BITS-1:0] load_data;
    logic [CNT_W-1:0]     load_count;
    logic                 bit_out;
    logic                 seg_done;
    logic                 in_fire;
    logic                 out_fire;
    logic [7:0]           addr_byte;

    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid && !out_stall;
    assign addr_byte = address_cmd_base_reg + {4'b0000, addr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_cmd_fixed_reg     <= RST_DATA_CMD_FIXED;
            data_cmd_increment_reg <= RST_DATA_CMD_INCREMENT;
            address_cmd_base_reg   <= RST_ADDRESS_CMD_BASE;
            display_ctrl_cmd_reg   <= RST_DISPLAY_CTRL_CMD;
            display_mode_cmd_reg   <= RST_DISPLAY_MODE_CMD;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DATA_CMD_FIXED:     data_cmd_fixed_reg     <= cfg_data;
                CFG_DATA_CMD_INCREMENT: data_cmd_increment_reg <= cfg_data;
                CFG_ADDRESS_CMD_BASE:   address_cmd_base_reg   <= cfg_data;
                CFG_DISPLAY_CTRL_CMD:   display_ctrl_cmd_reg   <= cfg_data;
                CFG_DISPLAY_MODE_CMD:   display_mode_cmd_reg   <= cfg_data;
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        burst_open_next   = burst_open_reg;
        mode_set_next     = mode_set_reg;
        word_release_next = word_release_reg;
        ctrl_pending_next = ctrl_pending_reg;
        sh_ctrl           = '0;
        load_data         = '0;
        load_count        = CMD_COUNT;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (kind)
                        KIND_MODE_SET:
                        begin
                            burst_open_next = 1'b0;
                            mode_set_next   = 1'b1;
                            sh_ctrl.load    = 1'b1;
                            load_data[7:0]  = display_mode_cmd_reg;
                            state_next      = ST_CMD;
                        end
                        KIND_FIXED:
                        begin
                            burst_open_next   = 1'b0;
                            mode_set_next     = 1'b0;
                            word_release_next = 1'b1;
                            ctrl_pending_next = 1'b1;
                            sh_ctrl.load      = 1'b1;
                            load_data[7:0]    = data_cmd_fixed_reg;
                            state_next        = ST_CMD;
                        end
                        KIND_BURST:
                        begin
                            burst_open_next   = !last_word;
                            mode_set_next     = 1'b0;
                            word_release_next = last_word;
                            ctrl_pending_next = last_word;
                            sh_ctrl.load      = 1'b1;
                            if (burst_open_reg)
                            begin
                                load_data  = word_data[DATA_BITS-1:0];
                                load_count = WORD_COUNT;
                                state_next = ST_WORD;
                            end
                            else
                            begin
                                load_data[7:0] = data_cmd_increment_reg;
                                state_next     = ST_CMD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CMD:
            begin
                if (out_fire)
                begin
                    if (!seg_done)
                    begin
                        sh_ctrl.shift = 1'b1;
                    end
                    else if (mode_set_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        sh_ctrl.load   = 1'b1;
                        load_data[7:0] = addr_byte;
                        state_next     = ST_ADDR;
                    end
                end
            end
            ST_ADDR:
            begin
                if (out_fire)
                begin
                    if (!seg_done)
                    begin
                        sh_ctrl.shift = 1'b1;
                    end
                    else
                    begin
                        sh_ctrl.load = 1'b1;
                        load_data    = word_reg;
                        load_count   = WORD_COUNT;
                        state_next   = ST_WORD;
                    end
                end
            end
            ST_WORD:
            begin
                if (out_fire)
                begin
                    if (!seg_done)
                    begin
                        sh_ctrl.shift = 1'b1;
                    end
                    else if (ctrl_pending_reg)
                    begin
                        sh_ctrl.load   = 1'b1;
                        load_data[7:0] = display_ctrl_cmd_reg;
                        state_next     = ST_CTRL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CTRL:
            begin
                if (out_fire)
                begin
                    if (!seg_done)
                    begin
                        sh_ctrl.shift = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            burst_open_reg   <= 1'b0;
            mode_set_reg     <= 1'b0;
            word_release_reg <= 1'b0;
            ctrl_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            burst_open_reg   <= burst_open_next;
            mode_set_reg     <= mode_set_next;
            word_release_reg <= word_release_next;
            ctrl_pending_reg <= ctrl_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            addr_reg <= display_address;
            word_reg <= word_data[DATA_BITS-1:0];
        end
    end

    lddsc_shifter #(
        .WIDTH (DATA_BITS)
    ) u_shifter (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (sh_ctrl),
        .load_data  (load_data),
        .load_count (load_count),
        .bit_out    (bit_out),
        .seg_done   (seg_done)
    );

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = (state_reg != ST_IDLE);
    assign serial_bit     = bit_out;
    assign strobe_release = seg_done && ((state_reg == ST_CMD) || (state_reg == ST_CTRL)
                            || ((state_reg == ST_WORD) && word_release_reg));
    assign last           = seg_done && (((state_reg == ST_CMD) && mode_set_reg)
                            || (state_reg == ST_CTRL)
                            || ((state_reg == ST_WORD) && !ctrl_pending_reg));

endmodule

@@ rtl/lddsc_checker.sv @@
// Port-level checker for the LED driver serial command sender, bound to the top level.
// Depends on lddsc_pkg for the request kind codes.
module lddsc_checker
    import lddsc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] kind,
    input logic       out_valid,
    input logic       out_stall,
    input logic       serial_bit,
    input logic       strobe_release,
    input logic       last
);

    logic in_fire;
    logic out_fire;

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    a_busy_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("A new request could be taken while results are pending.");

    a_request_starts_output: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (kind != KIND_UNUSED)) |=> out_valid)
        else $error("A valid request did not start serial output.");

    a_unused_kind_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (kind == KIND_UNUSED)) |=> !out_valid)
        else $error("An unused request kind produced output.");

    a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last) |=> !out_valid)
        else $error("Output continued after the final bit of a request.");

    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(serial_bit) && $stable(strobe_release) && $stable(last)))
        else $error("A stalled result changed.");

endmodule

bind led_driver_serial_command_sender_core lddsc_checker u_lddsc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .serial_bit     (serial_bit),
    .strobe_release (strobe_release),
    .last           (last)
);

@@ verif/tb_led_driver_serial_command_sender_core.sv @@
// Self-checking testbench for led_driver_serial_command_sender_core.
// Drives random and directed requests, predicts every serial bit and checks it.
// Depends on lddsc_pkg and the core RTL only.
module tb_led_driver_serial_command_sender_core
    import lddsc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BITS = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  addr;
        logic [15:0] word;
        logic        last_word;
    } request_t;

    typedef struct packed {
        logic data_bit;
        logic strobe_rel;
        logic req_end;
    } serial_bit_t;

    typedef struct packed {
        logic [15:0] val;
        logic [4:0]  len;
        logic        rel;
    } cmd_field_t;

    typedef struct packed {
        logic [7:0] fixed_cmd;
        logic [7:0] incr_cmd;
        logic [7:0] addr_base;
        logic [7:0] ctrl_cmd;
        logic [7:0] mode_cmd;
    } cmd_regs_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            kind = '0;
    logic [3:0]            display_address = '0;
    logic [15:0]           word_data = '0;
    logic                  last_word = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  serial_bit;
    logic                  strobe_release;
    logic                  last;

    request_t    pending_requests[$];
    serial_bit_t expected_bits[$];
    cmd_regs_t   cmd_regs;
    logic        burst_active;
    request_t    on_bus;
    bit          idle_on = 1'b1;
    int          send_gap = 0;
    int          stall_left = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    led_driver_serial_command_sender_core #(
        .DATA_BITS(WORD_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .display_address(display_address),
        .word_data      (word_data),
        .last_word      (last_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .serial_bit     (serial_bit),
        .strobe_release (strobe_release),
        .last           (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic cmd_field_t field(logic [15:0] val, int len, logic rel);
        cmd_field_t f;
        f.val = val;
        f.len = len[4:0];
        f.rel = rel;
        return f;
    endfunction

    function automatic void predict_request(request_t req);
        cmd_field_t  fields[$];
        serial_bit_t r;
        logic [7:0]  addr_byte;
        int          total;
        int          idx;
        addr_byte = cmd_regs.addr_base + {4'd0, req.addr};
        case (req.kind)
            KIND_MODE_SET:
            begin
                burst_active = 1'b0;
                fields.push_back(field({8'd0, cmd_regs.mode_cmd}, 8, 1'b1));
            end
            KIND_FIXED:
            begin
                burst_active = 1'b0;
                fields.push_back(field({8'd0, cmd_regs.fixed_cmd}, 8, 1'b1));
                fields.push_back(field({8'd0, addr_byte}, 8, 1'b0));
                fields.push_back(field(req.word, WORD_BITS, 1'b1));
                fields.push_back(field({8'd0, cmd_regs.ctrl_cmd}, 8, 1'b1));
            end
            KIND_BURST:
            begin
                if (!burst_active)
                begin
                    fields.push_back(field({8'd0, cmd_regs.incr_cmd}, 8, 1'b1));
                    fields.push_back(field({8'd0, addr_byte}, 8, 1'b0));
                end
                fields.push_back(field(req.word, WORD_BITS, req.last_word));
                if (req.last_word)
                    fields.push_back(field({8'd0, cmd_regs.ctrl_cmd}, 8, 1'b1));
                burst_active = !req.last_word;
            end
            default:
            begin
            end
        endcase
        total = 0;
        foreach (fields[i])
            total += fields[i].len;
        idx = 0;
        foreach (fields[i])
        begin
            for (int b = 0; b < fields[i].len; b++)
            begin
                r.data_bit   = fields[i].val[b];
                r.strobe_rel = fields[i].rel && (b == fields[i].len - 1);
                r.req_end    = (idx == total - 1);
                expected_bits.push_back(r);
                idx++;
            end
        end
    endfunction

    // Request driver.
    always @(posedge clk)
    begin
        logic take;
        take = in_valid && !in_stall;
        if (take)
        begin
            predict_request(on_bus);
            if (idle_on && $urandom_range(0, 3) == 0)
                send_gap = $urandom_range(1, 9);
        end
        if (!in_valid || take)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (rst_n && pending_requests.size() != 0)
            begin
                on_bus = pending_requests.pop_front();
                in_valid        <= 1'b1;
                kind            <= on_bus.kind;
                display_address <= on_bus.addr;
                word_data       <= on_bus.word;
                last_word       <= on_bus.last_word;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge clk)
    begin
        serial_bit_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (expected_bits.size() == 0)
            begin
                $error("unexpected result: serial_bit %0b strobe_release %0b last %0b",
                       serial_bit, strobe_release, last);
                error_count++;
            end
            else
            begin
                want = expected_bits.pop_front();
                if (serial_bit !== want.data_bit)
                begin
                    $error("serial_bit mismatch: expected %0b, got %0b", want.data_bit, serial_bit);
                    error_count++;
                end
                if (strobe_release !== want.strobe_rel)
                begin
                    $error("strobe_release mismatch: expected %0b, got %0b",
                           want.strobe_rel, strobe_release);
                    error_count++;
                end
                if (last !== want.req_end)
                begin
                    $error("last mismatch: expected %0b, got %0b", want.req_end, last);
                    error_count++;
                end
            end
        end
        if (!idle_on)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 8);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("led_driver_serial_command_sender_core verification failed");
            $finish;
        end
    end

    function automatic logic [15:0] rand_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 16'h0000;
        if (pick == 1)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic queue_request(kind_t k, logic [3:0] addr, logic [15:0] word, logic lw);
        request_t req;
        req.kind      = k;
        req.addr      = addr;
        req.word      = word;
        req.last_word = lw;
        pending_requests.push_back(req);
    endtask

    task automatic queue_burst(int words, logic closed);
        for (int i = 0; i < words; i++)
            queue_request(KIND_BURST, 4'($urandom_range(0, 15)), rand_word(),
                          closed && (i == words - 1));
    endtask

    task automatic queue_random(int count);
        int made;
        int pick;
        int n;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                queue_request(KIND_MODE_SET, 4'($urandom_range(0, 15)), rand_word(),
                              1'($urandom_range(0, 1)));
                made++;
            end
            else if (pick < 40)
            begin
                queue_request(KIND_FIXED, 4'($urandom_range(0, 15)), rand_word(),
                              1'($urandom_range(0, 1)));
                made++;
            end
            else if (pick < 85)
            begin
                n = $urandom_range(1, 5);
                queue_burst(n, 1'b1);
                made += n;
            end
            else if (pick < 92)
                queue_request(KIND_UNUSED, 4'($urandom_range(0, 15)), rand_word(),
                              1'($urandom_range(0, 1)));
            else
            begin
                n = $urandom_range(1, 3);
                queue_burst(n, 1'b0);
                made += n;
            end
        end
    endtask

    task automatic write_reg(cfg_index_t idx, logic [7:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_DATA_CMD_FIXED:     cmd_regs.fixed_cmd = val;
            CFG_DATA_CMD_INCREMENT: cmd_regs.incr_cmd  = val;
            CFG_ADDRESS_CMD_BASE:   cmd_regs.addr_base = val;
            CFG_DISPLAY_CTRL_CMD:   cmd_regs.ctrl_cmd  = val;
            CFG_DISPLAY_MODE_CMD:   cmd_regs.mode_cmd  = val;
            default:
            begin
            end
        endcase
    endtask

    task automatic write_all(logic [7:0] f, logic [7:0] i, logic [7:0] a,
                             logic [7:0] c, logic [7:0] m);
        write_reg(CFG_DATA_CMD_FIXED, f);
        write_reg(CFG_DATA_CMD_INCREMENT, i);
        write_reg(CFG_ADDRESS_CMD_BASE, a);
        write_reg(CFG_DISPLAY_CTRL_CMD, c);
        write_reg(CFG_DISPLAY_MODE_CMD, m);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_bits.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        cmd_regs.fixed_cmd = RST_DATA_CMD_FIXED;
        cmd_regs.incr_cmd  = RST_DATA_CMD_INCREMENT;
        cmd_regs.addr_base = RST_ADDRESS_CMD_BASE;
        cmd_regs.ctrl_cmd  = RST_DISPLAY_CTRL_CMD;
        cmd_regs.mode_cmd  = RST_DISPLAY_MODE_CMD;
        burst_active = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // An unused kind inside an open burst must leave the burst open, and
        // a mode-set or fixed write abandons a burst without display control.
        queue_request(KIND_MODE_SET, 4'd0, 16'h0000, 1'b0);
        queue_request(KIND_FIXED, 4'd0, 16'h0000, 1'b0);
        queue_request(KIND_FIXED, 4'd15, 16'hFFFF, 1'b1);
        queue_request(KIND_FIXED, 4'd5, 16'h0001, 1'b0);
        queue_request(KIND_BURST, 4'd15, 16'h8000, 1'b1);
        queue_request(KIND_BURST, 4'd3, 16'hA5A5, 1'b0);
        queue_request(KIND_BURST, 4'd9, 16'h5A5A, 1'b0);
        queue_request(KIND_UNUSED, 4'd15, 16'hFFFF, 1'b1);
        queue_request(KIND_BURST, 4'd0, 16'h1234, 1'b1);
        queue_request(KIND_BURST, 4'd2, 16'hFFFF, 1'b0);
        queue_request(KIND_MODE_SET, 4'd15, 16'hFFFF, 1'b1);
        queue_request(KIND_BURST, 4'd7, 16'h0001, 1'b0);
        queue_request(KIND_FIXED, 4'd1, 16'hFFFF, 1'b0);
        queue_request(KIND_UNUSED, 4'd0, 16'h0000, 1'b0);
        queue_request(KIND_BURST, 4'd0, 16'hFFFF, 1'b0);
        queue_request(KIND_BURST, 4'd12, 16'h0000, 1'b0);
        queue_request(KIND_BURST, 4'd6, 16'h0001, 1'b1);
        queue_request(KIND_MODE_SET, 4'd8, 16'h7FFF, 1'b0);
        wait_idle();

        write_all(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_random(25);
        wait_idle();

        write_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_random(25);
        wait_idle();

        for (int p = 0; p < 3; p++)
        begin
            write_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
            idle_on = (p != 1);
            queue_random(30);
            wait_idle();
        end

        idle_on = 1'b0;
        write_all(RST_DATA_CMD_FIXED, RST_DATA_CMD_INCREMENT, RST_ADDRESS_CMD_BASE,
                  RST_DISPLAY_CTRL_CMD, RST_DISPLAY_MODE_CMD);
        queue_random(20);
        wait_idle();
        repeat (50) @(posedge clk);

        if (error_count == 0)
            $display("led_driver_serial_command_sender_core verification clean");
        else
            $display("led_driver_serial_command_sender_core verification failed");
        $finish;
    end

endmodule

@@ led_driver_serial_command_sender_core.f @@
rtl/lddsc_pkg.sv
rtl/lddsc_shifter.sv
rtl/led_driver_serial_command_sender_core.sv
rtl/lddsc_checker.sv
verif/tb_led_driver_serial_command_sender_core.sv
